// ===== design/prbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the pinned, reference-counted block cache tag table.
// No dependencies; used by the top level.
package prbc_pkg;

   typedef enum logic [2:0] {
      KIND_RETRIEVE = 3'd0,
      KIND_DONE     = 3'd1,
      KIND_PIN      = 3'd2,
      KIND_UNPIN    = 3'd3,
      KIND_MODIFIED = 3'd4,
      KIND_SYNC     = 3'd5,
      KIND_FLUSH    = 3'd6,
      KIND_DROP     = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_HIT    = 3'd0,
      ST_MISS   = 3'd1,
      ST_OK     = 3'd2,
      ST_WB     = 3'd3,
      ST_REL    = 3'd4,
      ST_NONE   = 3'd5,
      ST_NOTC   = 3'd6,
      ST_NOVIC  = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_RD   = 2'd1,
      S_EVAL = 2'd2,
      S_FIN  = 2'd3
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] block_number;
      logic        pin_on_load;
      logic        was_modified;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [31:0] block_id;
      logic        victim_valid;
      logic [31:0] victim_block;
      logic        writeback;
      logic [15:0] ref_count;
      logic        last;
   } rsp_type;

   localparam int STAMP_BITS = 64;

endpackage

// ===== design/prbc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module prbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pinned_refcounted_block_cache_core.sv =====
`timescale 1ns / 1ps
// Top level of the pinned, reference-counted block cache tag table.
// Depends on prbc_pkg and prbc_ram.
//
//   Channel | Ports                          | Beat carries
//   --------+--------------------------------+-----------------------------------
//   request | req_valid req_ready req_payload | one command (kind, block, flags)
//   result  | rsp_valid rsp_ready rsp_payload | one result; last marks the final one
//
// Every command walks all slots through the entry RAM, each slot in a read state
// (S_RD) then an evaluate state (S_EVAL), between accept (S_IDLE) and finish
// (S_FIN). The registered read of the entry RAM sets the separate read and evaluate
// steps. Reset empties the table at once (valid bits are flip-flops) and refills
// the free list; no clearing pass is needed. A stalled result side holds the walk
// in place; one result is buffered in the output register and one more waits in
// the pending register so that last can be set.
module pinned_refcounted_block_cache_core #(
   parameter int NUM_SLOTS = 16,
   parameter int REF_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prbc_pkg::rsp_type rsp_payload
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);
   localparam logic [SW:0] FULL_COUNT = (SW + 1)'(NUM_SLOTS);
   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   // One RAM word per slot holds everything but the valid bit.
   typedef struct packed {
      logic [31:0]                     blk;
      logic [REF_BITS-1:0]             refs;
      logic                            pinned;
      logic                            dirty;
      logic [prbc_pkg::STAMP_BITS-1:0] stamp;
   } entry_type;

   prbc_pkg::state_type state_ff, state_in;
   prbc_pkg::req_type   req_ff, req_in;
   logic [SW-1:0]       idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       hit_slot_ff, hit_slot_in;
   entry_type           hit_word_ff, hit_word_in;
   logic                vic_found_ff, vic_found_in;
   logic [SW-1:0]       vic_slot_ff, vic_slot_in;
   logic [prbc_pkg::STAMP_BITS-1:0] vic_stamp_ff, vic_stamp_in;
   logic [31:0]         vic_block_ff, vic_block_in;
   logic                vic_dirty_ff, vic_dirty_in;
   logic                pend_valid_ff, pend_valid_in;
   prbc_pkg::rsp_type   pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   prbc_pkg::rsp_type   rsp_ff, rsp_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [SW-1:0]       fifo_ff [NUM_SLOTS];
   logic [SW-1:0]       fifo_in [NUM_SLOTS];
   logic [SW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [SW:0]         count_ff, count_in;
   logic [prbc_pkg::STAMP_BITS-1:0] stamp_ff, stamp_in;

   logic                ram_we;
   logic [SW-1:0]       ram_waddr;
   entry_type           ram_wdata;
   entry_type           rword;

   logic out_free, is_walk, cur_valid, walk_report, walk_stall;

   prbc_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(NUM_SLOTS)
   ) u_entries (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(idx_ff),
      .rd_data(rword)
   );

   function automatic logic [3:0] slot_field(input logic [SW-1:0] s);
      logic [SW+3:0] ext;
      ext = {4'b0, s};
      return ext[3:0];
   endfunction

   function automatic logic [15:0] ref_field(input logic [REF_BITS-1:0] r);
      logic [REF_BITS+15:0] ext;
      ext = {16'b0, r};
      return ext[15:0];
   endfunction

   function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + SW'(1);
   endfunction

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == prbc_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign is_walk     = (req_ff.kind == prbc_pkg::KIND_SYNC) ||
                        (req_ff.kind == prbc_pkg::KIND_FLUSH) ||
                        (req_ff.kind == prbc_pkg::KIND_DROP);
   assign cur_valid   = valid_ff[idx_ff];
   assign walk_report = is_walk && cur_valid &&
                        ((req_ff.kind != prbc_pkg::KIND_SYNC) || rword.dirty);
   // A second reportable entry needs the pending result moved out first.
   assign walk_stall  = walk_report && pend_valid_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prbc_pkg::S_IDLE: begin
            if (req_valid) state_in = prbc_pkg::S_RD;
         end
         prbc_pkg::S_RD: state_in = prbc_pkg::S_EVAL;
         prbc_pkg::S_EVAL: begin
            if (!walk_stall) begin
               state_in = (idx_ff == LAST_IDX) ? prbc_pkg::S_FIN : prbc_pkg::S_RD;
            end
         end
         prbc_pkg::S_FIN: begin
            if (out_free) state_in = prbc_pkg::S_IDLE;
         end
         default: state_in = prbc_pkg::S_IDLE;
      endcase
   end

   // Datapath and table updates.
   always_comb begin
      entry_type nw;
      logic [SW-1:0] ns;
      req_in        = req_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_word_in   = hit_word_ff;
      vic_found_in  = vic_found_ff;
      vic_slot_in   = vic_slot_ff;
      vic_stamp_in  = vic_stamp_ff;
      vic_block_in  = vic_block_ff;
      vic_dirty_in  = vic_dirty_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      valid_in      = valid_ff;
      fifo_in       = fifo_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = rword;
      nw            = hit_word_ff;
      ns            = fifo_ff[head_ff];

      unique case (state_ff)
         prbc_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               idx_in        = '0;
               found_in      = 1'b0;
               vic_found_in  = 1'b0;
               pend_valid_in = 1'b0;
            end
         end
         prbc_pkg::S_RD: begin
         end
         prbc_pkg::S_EVAL: begin
            if (!walk_stall) begin
               if (idx_ff != LAST_IDX) idx_in = idx_ff + SW'(1);
            end
            if (!is_walk) begin
               if (cur_valid && rword.blk == req_ff.block_number && !found_ff) begin
                  found_in    = 1'b1;
                  hit_slot_in = idx_ff;
                  hit_word_in = rword;
               end
               if (req_ff.kind == prbc_pkg::KIND_RETRIEVE && cur_valid &&
                   !rword.pinned && rword.refs == '0 &&
                   (!vic_found_ff || rword.stamp < vic_stamp_ff)) begin
                  vic_found_in = 1'b1;
                  vic_slot_in  = idx_ff;
                  vic_stamp_in = rword.stamp;
                  vic_block_in = rword.blk;
                  vic_dirty_in = rword.dirty;
               end
            end else if (walk_report && !walk_stall) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_valid_in        = 1'b1;
               pend_in              = '0;
               pend_in.slot         = slot_field(idx_ff);
               pend_in.block_id     = rword.blk;
               pend_in.ref_count    = ref_field(rword.refs);
               if (req_ff.kind == prbc_pkg::KIND_SYNC) begin
                  pend_in.status    = prbc_pkg::ST_WB;
                  pend_in.writeback = 1'b1;
                  ram_we            = 1'b1;
                  ram_wdata.dirty   = 1'b0;
               end else begin
                  pend_in.status    = prbc_pkg::ST_REL;
                  pend_in.writeback = (req_ff.kind == prbc_pkg::KIND_FLUSH) && rword.dirty;
                  valid_in[idx_ff]  = 1'b0;
                  if (count_ff < FULL_COUNT) begin
                     fifo_in[tail_ff] = idx_ff;
                     tail_in          = wrap_inc(tail_ff);
                     count_in         = count_ff + (SW + 1)'(1);
                  end
               end
            end
         end
         prbc_pkg::S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               if (is_walk) begin
                  if (pend_valid_ff) begin
                     rsp_in      = pend_ff;
                     rsp_in.last = 1'b1;
                  end else begin
                     rsp_in.status = prbc_pkg::ST_NONE;
                  end
               end else if (req_ff.kind == prbc_pkg::KIND_RETRIEVE) begin
                  rsp_in.block_id = req_ff.block_number;
                  if (found_ff) begin
                     if (hit_word_ff.refs != REF_MAX) begin
                        nw.refs = hit_word_ff.refs + REF_BITS'(1);
                     end
                     ram_we           = 1'b1;
                     ram_waddr        = hit_slot_ff;
                     ram_wdata        = nw;
                     rsp_in.status    = prbc_pkg::ST_HIT;
                     rsp_in.slot      = slot_field(hit_slot_ff);
                     rsp_in.ref_count = ref_field(nw.refs);
                  end else if (count_ff == '0 && !vic_found_ff) begin
                     rsp_in.status = prbc_pkg::ST_NOVIC;
                  end else begin
                     if (count_ff == '0) begin
                        // Evict into the tail, then pop the same slot from the head.
                        ns               = vic_slot_ff;
                        fifo_in[tail_ff] = vic_slot_ff;
                        tail_in          = wrap_inc(tail_ff);
                        rsp_in.victim_valid = 1'b1;
                        rsp_in.victim_block = vic_block_ff;
                        rsp_in.writeback    = vic_dirty_ff;
                     end else begin
                        count_in = count_ff - (SW + 1)'(1);
                     end
                     head_in          = wrap_inc(head_ff);
                     valid_in[ns]     = 1'b1;
                     nw.blk           = req_ff.block_number;
                     nw.refs          = REF_BITS'(1);
                     nw.pinned        = req_ff.pin_on_load;
                     nw.dirty         = 1'b0;
                     nw.stamp         = stamp_ff;
                     stamp_in         = stamp_ff + {{(prbc_pkg::STAMP_BITS-1){1'b0}}, 1'b1};
                     ram_we           = 1'b1;
                     ram_waddr        = ns;
                     ram_wdata        = nw;
                     rsp_in.status    = prbc_pkg::ST_MISS;
                     rsp_in.slot      = slot_field(ns);
                     rsp_in.ref_count = 16'd1;
                  end
               end else begin
                  rsp_in.block_id = req_ff.block_number;
                  if (!found_ff) begin
                     rsp_in.status = prbc_pkg::ST_NOTC;
                  end else begin
                     priority case (req_ff.kind)
                        prbc_pkg::KIND_DONE: begin
                           if (hit_word_ff.refs != '0) begin
                              nw.refs = hit_word_ff.refs - REF_BITS'(1);
                           end
                           if (req_ff.was_modified) nw.dirty = 1'b1;
                        end
                        prbc_pkg::KIND_PIN:   nw.pinned = 1'b1;
                        prbc_pkg::KIND_UNPIN: nw.pinned = 1'b0;
                        default:              nw.dirty  = 1'b1;
                     endcase
                     ram_we           = 1'b1;
                     ram_waddr        = hit_slot_ff;
                     ram_wdata        = nw;
                     rsp_in.status    = prbc_pkg::ST_OK;
                     rsp_in.slot      = slot_field(hit_slot_ff);
                     rsp_in.ref_count = ref_field(nw.refs);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= prbc_pkg::S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= FULL_COUNT;
         stamp_ff      <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            fifo_ff[i] <= SW'(i);
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         stamp_ff      <= stamp_in;
         fifo_ff       <= fifo_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      hit_slot_ff  <= hit_slot_in;
      hit_word_ff  <= hit_word_in;
      vic_found_ff <= vic_found_in;
      vic_slot_ff  <= vic_slot_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_block_ff <= vic_block_in;
      vic_dirty_ff <= vic_dirty_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   // Every slot is either in the table or on the free list, never both.
   a_slot_conservation: assert property (@(posedge clock) disable iff (reset)
      ($countones(valid_ff) + 32'(count_ff)) == NUM_SLOTS)
      else $error("free count and valid slots disagree");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("free list overflow");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prbc_pkg::S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind after a walk");

endmodule

// ===== tb/tb_pinned_refcounted_block_cache_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pinned_refcounted_block_cache_core: a directed table, then
// random commands under several idling patterns, checked against an in-bench cache predictor.
// Depends on prbc_pkg and the design files of the block.
module tb_pinned_refcounted_block_cache_core;

   localparam int SLOTS     = 16;
   localparam int REF_LIMIT = 65535;
   localparam int POOL_SIZE = 20;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   prbc_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   prbc_pkg::rsp_type rsp_payload;

   pinned_refcounted_block_cache_core #(.NUM_SLOTS(SLOTS), .REF_BITS(16)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // Shadow copy of the tag table.
   bit          slot_valid [SLOTS];
   logic [31:0] slot_block [SLOTS];
   int unsigned slot_refs  [SLOTS];
   bit          slot_pinned[SLOTS];
   bit          slot_dirty [SLOTS];
   logic [63:0] slot_stamp [SLOTS];
   logic [63:0] next_stamp;
   int          free_slots[$];

   prbc_pkg::rsp_type owed_results[$];
   int          error_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_go;
   logic [31:0] block_pool[POOL_SIZE];

   typedef struct {
      prbc_pkg::req_type rq;
      bit                typed;
      prbc_pkg::rsp_type want;
   } table_row;
   table_row directed_rows[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_pinned_refcounted_block_cache_core NOT OK");
      $finish;
   end

   function automatic prbc_pkg::rsp_type make_rsp(prbc_pkg::status_type st, int sl,
                                                  logic [31:0] blk, bit vv, logic [31:0] vb,
                                                  bit wb, int refs, bit fin);
      prbc_pkg::rsp_type r;
      r.status       = st;
      r.slot         = sl[3:0];
      r.block_id     = blk;
      r.victim_valid = vv;
      r.victim_block = vb;
      r.writeback    = wb;
      r.ref_count    = refs[15:0];
      r.last         = fin;
      return r;
   endfunction

   function automatic int find_block(logic [31:0] blk);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_block[i] == blk) return i;
      return -1;
   endfunction

   // Works out the results of one command and updates the shadow table.
   function automatic void predict_cache_command(prbc_pkg::req_type rq,
                                                 ref prbc_pkg::rsp_type res[$]);
      int s;
      int victim;
      int n;
      bit vv;
      logic [31:0] vb;
      bit wb;
      res.delete();
      vv = 0; vb = '0; wb = 0;
      if (rq.kind == prbc_pkg::KIND_RETRIEVE) begin
         s = find_block(rq.block_number);
         if (s >= 0) begin
            if (slot_refs[s] < REF_LIMIT) slot_refs[s]++;
            res.push_back(make_rsp(prbc_pkg::ST_HIT, s, rq.block_number, 0, '0, 0,
                                   slot_refs[s], 1));
            return;
         end
         if (free_slots.size() == 0) begin
            // Oldest unpinned, unreferenced entry goes.
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i] && !slot_pinned[i] && slot_refs[i] == 0 &&
                   (victim < 0 || slot_stamp[i] < slot_stamp[victim]))
                  victim = i;
            if (victim < 0) begin
               res.push_back(make_rsp(prbc_pkg::ST_NOVIC, 0, rq.block_number, 0, '0, 0, 0, 1));
               return;
            end
            vv = 1;
            vb = slot_block[victim];
            wb = slot_dirty[victim];
            slot_valid[victim] = 0;
            slot_dirty[victim] = 0;
            free_slots.push_back(victim);
         end
         s = free_slots.pop_front();
         slot_valid[s]  = 1;
         slot_block[s]  = rq.block_number;
         slot_refs[s]   = 1;
         slot_dirty[s]  = 0;
         slot_pinned[s] = rq.pin_on_load;
         slot_stamp[s]  = next_stamp;
         next_stamp     = next_stamp + 64'd1;
         res.push_back(make_rsp(prbc_pkg::ST_MISS, s, rq.block_number, vv, vb, wb, 1, 1));
      end else if (rq.kind == prbc_pkg::KIND_SYNC || rq.kind == prbc_pkg::KIND_FLUSH ||
                   rq.kind == prbc_pkg::KIND_DROP) begin
         n = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i]) continue;
            if (rq.kind == prbc_pkg::KIND_SYNC) begin
               if (!slot_dirty[i]) continue;
               slot_dirty[i] = 0;
               res.push_back(make_rsp(prbc_pkg::ST_WB, i, slot_block[i], 0, '0, 1,
                                      slot_refs[i], 0));
            end else begin
               res.push_back(make_rsp(prbc_pkg::ST_REL, i, slot_block[i], 0, '0,
                                      rq.kind == prbc_pkg::KIND_FLUSH && slot_dirty[i],
                                      slot_refs[i], 0));
               slot_valid[i] = 0;
               slot_dirty[i] = 0;
               free_slots.push_back(i);
            end
            n++;
         end
         if (n == 0) res.push_back(make_rsp(prbc_pkg::ST_NONE, 0, '0, 0, '0, 0, 0, 1));
         else res[n-1].last = 1;
      end else begin
         s = find_block(rq.block_number);
         if (s < 0) begin
            res.push_back(make_rsp(prbc_pkg::ST_NOTC, 0, rq.block_number, 0, '0, 0, 0, 1));
            return;
         end
         unique case (rq.kind)
            prbc_pkg::KIND_DONE: begin
               if (slot_refs[s] > 0) slot_refs[s]--;
               if (rq.was_modified) slot_dirty[s] = 1;
            end
            prbc_pkg::KIND_PIN:   slot_pinned[s] = 1;
            prbc_pkg::KIND_UNPIN: slot_pinned[s] = 0;
            default:              slot_dirty[s] = 1;
         endcase
         res.push_back(make_rsp(prbc_pkg::ST_OK, s, rq.block_number, 0, '0, 0,
                                slot_refs[s], 1));
      end
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: result field %s got 0x%0h, expected 0x%0h", $time, field, got, want);
      error_count++;
   endtask

   // Result side: every beat is held against the oldest owed result.
   always @(posedge clock) begin
      prbc_pkg::rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            report_mismatch("unexpected beat", 64'(rsp_payload.block_id), 64'd0);
         end else begin
            w = owed_results.pop_front();
            if (rsp_payload.status != w.status)
               report_mismatch("status", 64'(rsp_payload.status), 64'(w.status));
            if (rsp_payload.slot != w.slot)
               report_mismatch("slot", 64'(rsp_payload.slot), 64'(w.slot));
            if (rsp_payload.block_id != w.block_id)
               report_mismatch("block_id", 64'(rsp_payload.block_id), 64'(w.block_id));
            if (rsp_payload.victim_valid != w.victim_valid)
               report_mismatch("victim_valid", 64'(rsp_payload.victim_valid),
                               64'(w.victim_valid));
            if (rsp_payload.victim_block != w.victim_block)
               report_mismatch("victim_block", 64'(rsp_payload.victim_block),
                               64'(w.victim_block));
            if (rsp_payload.writeback != w.writeback)
               report_mismatch("writeback", 64'(rsp_payload.writeback), 64'(w.writeback));
            if (rsp_payload.ref_count != w.ref_count)
               report_mismatch("ref_count", 64'(rsp_payload.ref_count), 64'(w.ref_count));
            if (rsp_payload.last != w.last)
               report_mismatch("last", 64'(rsp_payload.last), 64'(w.last));
         end
      end
   end

   // Receiver readiness. The one long hold-off is counted here, in cycles, so the
   // sender keeps offering commands until the block backs up and drops req_ready.
   int  hold_left = 400;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one command, waits until it is taken, and records what it owes. A typed
   // expectation replaces the predicted one, but the predictor still runs so
   // that the shadow table stays in step.
   task automatic send_command(prbc_pkg::req_type rq, bit typed, prbc_pkg::rsp_type want);
      prbc_pkg::rsp_type res[$];
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (!req_ready);
      predict_cache_command(rq, res);
      if (typed) owed_results.push_back(want);
      else foreach (res[i]) owed_results.push_back(res[i]);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic add_row(prbc_pkg::kind_type k, logic [31:0] blk, bit pin, bit modif,
                          bit typed, prbc_pkg::status_type st, int sl, int refs);
      table_row r;
      r.rq.kind         = k;
      r.rq.block_number = blk;
      r.rq.pin_on_load  = pin;
      r.rq.was_modified = modif;
      r.typed           = typed;
      r.want = make_rsp(st, sl, (st == prbc_pkg::ST_NONE) ? 32'h0 : blk, 0, '0, 0, refs, 1);
      directed_rows.push_back(r);
   endtask

   // Mostly well-formed traffic on a small block pool (larger than the table, so
   // evictions happen), with a slice of fully random noise.
   function automatic prbc_pkg::req_type random_command();
      prbc_pkg::req_type rq;
      int pick;
      pick = $urandom_range(99);
      rq.block_number = block_pool[$urandom_range(POOL_SIZE - 1)];
      rq.pin_on_load  = ($urandom_range(99) < 20);
      rq.was_modified = 1'($urandom_range(1));
      if (pick < 5) begin
         rq.kind         = prbc_pkg::kind_type'($urandom_range(7));
         rq.block_number = $urandom;
      end
      else if (pick < 50) rq.kind = prbc_pkg::KIND_RETRIEVE;
      else if (pick < 75) rq.kind = prbc_pkg::KIND_DONE;
      else if (pick < 80) rq.kind = prbc_pkg::KIND_PIN;
      else if (pick < 87) rq.kind = prbc_pkg::KIND_UNPIN;
      else if (pick < 91) rq.kind = prbc_pkg::KIND_MODIFIED;
      else if (pick < 95) rq.kind = prbc_pkg::KIND_SYNC;
      else if (pick < 98) rq.kind = prbc_pkg::KIND_FLUSH;
      else rq.kind = prbc_pkg::KIND_DROP;
      return rq;
   endfunction

   task automatic wait_drained();
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      prbc_pkg::rsp_type none_rsp;
      int      wait_cycles;
      none_rsp       = '0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go        = 1'b0;
      req_valid      = 1'b0;
      req_payload    = '0;
      reset          = 1'b1;
      next_stamp     = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 0;
         free_slots.push_back(i);
      end
      block_pool[0] = 32'h0;
      block_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = $urandom;

      // Directed table: empty walks, field extremes, every kind, pin ignored on a
      // hit, count saturating at zero, absent blocks, then sync, flush and drop.
      add_row(prbc_pkg::KIND_SYNC,     32'h0,         0, 0, 1, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_DONE,     32'hFFFF_FFFF, 0, 1, 1, prbc_pkg::ST_NOTC, 0, 0);
      add_row(prbc_pkg::KIND_RETRIEVE, 32'h0,         0, 0, 1, prbc_pkg::ST_MISS, 0, 1);
      add_row(prbc_pkg::KIND_RETRIEVE, 32'hFFFF_FFFF, 1, 0, 1, prbc_pkg::ST_MISS, 1, 1);
      add_row(prbc_pkg::KIND_RETRIEVE, 32'h0,         1, 1, 1, prbc_pkg::ST_HIT,  0, 2);
      add_row(prbc_pkg::KIND_DONE,     32'h0,         0, 1, 1, prbc_pkg::ST_OK,   0, 1);
      add_row(prbc_pkg::KIND_DONE,     32'h0,         1, 0, 1, prbc_pkg::ST_OK,   0, 0);
      add_row(prbc_pkg::KIND_DONE,     32'h0,         0, 0, 1, prbc_pkg::ST_OK,   0, 0);
      add_row(prbc_pkg::KIND_PIN,      32'hFFFF_FFFF, 0, 0, 1, prbc_pkg::ST_OK,   1, 1);
      add_row(prbc_pkg::KIND_UNPIN,    32'hFFFF_FFFF, 0, 0, 1, prbc_pkg::ST_OK,   1, 1);
      add_row(prbc_pkg::KIND_MODIFIED, 32'hFFFF_FFFF, 0, 0, 1, prbc_pkg::ST_OK,   1, 1);
      add_row(prbc_pkg::KIND_PIN,      32'h5,         0, 0, 1, prbc_pkg::ST_NOTC, 0, 0);
      add_row(prbc_pkg::KIND_UNPIN,    32'h5,         0, 0, 1, prbc_pkg::ST_NOTC, 0, 0);
      add_row(prbc_pkg::KIND_MODIFIED, 32'h5,         0, 0, 1, prbc_pkg::ST_NOTC, 0, 0);
      add_row(prbc_pkg::KIND_SYNC,     32'h0,         0, 0, 0, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_SYNC,     32'h0,         0, 0, 1, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_RETRIEVE, 32'hA5A5_A5A5, 1, 0, 0, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_DONE,     32'h0,         0, 1, 0, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_FLUSH,    32'h0,         0, 0, 0, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_DROP,     32'h0,         0, 0, 1, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_RETRIEVE, 32'h7,         0, 1, 0, prbc_pkg::ST_NONE, 0, 0);
      add_row(prbc_pkg::KIND_DROP,     32'h0,         0, 0, 0, prbc_pkg::ST_NONE, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_command(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

      // Random phases: no idling, sender idle, receiver stalling, then both.
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         // Long receiver hold-off at the start of the stall phase.
         if (phase == 2) hold_go = 1'b1;
         for (int n = 0; n < 48; n++) send_command(random_command(), 0, none_rsp);
         // Sender pauses with valid low until everything owed has come back.
         if (phase == 1) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (owed_results.size() != 0 && wait_cycles < 200_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && owed_results.size() == 0) begin
         $display("tb_pinned_refcounted_block_cache_core OK");
      end else begin
         if (owed_results.size() != 0)
            $display("%0d expected results never arrived", owed_results.size());
         $display("tb_pinned_refcounted_block_cache_core NOT OK");
      end
      $finish;
   end

endmodule
